// File: hw/rtl/jitter_buffer_loss_classifier_top_assert.svh
// Assertion macros for the jitter buffer loss classifier checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef JITTER_BUFFER_LOSS_CLASSIFIER_TOP_ASSERT_SVH
`define JITTER_BUFFER_LOSS_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define JBLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/jblc_pkg.sv
// Shared types and constants for the jitter buffer loss classifier.
// No dependencies.
package jblc_pkg;

  localparam int CMD_W      = 2;
  localparam int DLY_IN_W   = 12;
  localparam int DLY_W      = 11;
  localparam int TGT_W      = 14;
  localparam int FPP_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // late share is compared in hundredths of percent
  localparam logic [TGT_W-1:0] LATE_SCALE = 14'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_SELECT   = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_LD_RD,
    ST_LD_WR,
    ST_SEL_INIT,
    ST_SEL_RD,
    ST_SEL_MUL,
    ST_SEL_ACC,
    ST_CLS,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic ld_update;
    logic sel_init;
    logic sel_mul;
    logic sel_next;
    logic pick_addr;
    logic pick_fixed;
    logic cls_count;
    logic emit;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic clr_last;
    logic target_zero;
    logic sel_hit;
    logic sel_bottom;
    logic eff_zero;
    logic two_frames;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/jblc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jblc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/jblc_dp.sv
// Datapath: config registers, histogram RAM, counters, select accumulator
// and result register. Depends on jblc_pkg and jblc_ram.
module jblc_dp #(
  parameter int DELAY_BINS  = 2000,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [jblc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jblc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [jblc_pkg::CMD_W-1:0]         in_command,
  input  logic signed [jblc_pkg::DLY_IN_W-1:0] in_delay_ms,
  input  jblc_pkg::ctrl_cmd_t                ctl,
  output jblc_pkg::dp_status_t               sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_frame_lost,
  output logic                               out_last_of_run,
  output logic [jblc_pkg::DLY_W-1:0]         out_selected_delay,
  output logic                               out_range_error,
  output logic [COUNT_WIDTH-1:0]             out_sample_count,
  output logic [COUNT_WIDTH-1:0]             out_network_losses,
  output logic [COUNT_WIDTH-1:0]             out_late_losses
);

  import jblc_pkg::*;

  localparam int BIN_AW = $clog2(DELAY_BINS);
  localparam int BIN_CW = DLY_IN_W + 1;
  localparam int PROD_W = COUNT_WIDTH + TGT_W;
  localparam int ACC_W  = PROD_W + BIN_AW;
  localparam logic [BIN_CW-1:0]      TOP_BIN  = BIN_CW'(DELAY_BINS - 1);
  localparam logic [BIN_AW-1:0]      ADDR_TOP = BIN_AW'(DELAY_BINS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  logic [TGT_W-1:0]       tgt_r;
  logic [DLY_W-1:0]       fixed_r;
  logic [FPP_W-1:0]       fpp_r;
  cmd_t                   cmd_r;
  logic [DLY_IN_W-1:0]    dly_r;
  logic [BIN_AW-1:0]      addr_r;
  logic [COUNT_WIDTH-1:0] sample_r;
  logic [COUNT_WIDTH-1:0] netloss_r;
  logic [COUNT_WIDTH-1:0] lateloss_r;
  logic [DLY_W-1:0]       eff_r;
  logic [PROD_W-1:0]      limit_r;
  logic [PROD_W-1:0]      prod_r;
  logic [ACC_W-1:0]       acc_r;
  logic                   out_valid_r;
  logic                   out_lost_r;
  logic                   out_last_r;
  logic [DLY_W-1:0]       out_sel_r;
  logic                   out_err_r;
  logic [COUNT_WIDTH-1:0] out_samp_r;
  logic [COUNT_WIDTH-1:0] out_net_r;
  logic [COUNT_WIDTH-1:0] out_late_r;

  logic                   d_m1;
  logic                   d_neg;
  logic                   in_bins;
  logic                   bad;
  logic                   late;
  logic                   lost;
  logic [DLY_W-1:0]       fixed_clamp;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic                   ram_we;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [ACC_W-1:0]       acc_sum;
  logic                   hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r   <= '0;
      fixed_r <= '0;
      fpp_r   <= FPP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET: tgt_r   <= cfg_wdata[TGT_W-1:0];
        CFG_FIXED:  fixed_r <= cfg_wdata[DLY_W-1:0];
        CFG_FRAMES: fpp_r   <= cfg_wdata[FPP_W-1:0];
        default: ;
      endcase
    end
  end

  // delay decode on the captured sample
  always_comb begin
    d_m1    = (dly_r == '1);
    d_neg   = dly_r[DLY_IN_W-1];
    in_bins = !d_neg && (BIN_CW'(dly_r) <= TOP_BIN);
    bad     = !in_bins && !d_m1;
    late    = !d_m1 && (d_neg || (dly_r > DLY_IN_W'(eff_r)));
    lost    = d_m1 || late;
    fixed_clamp = (BIN_CW'(fixed_r) > TOP_BIN) ? DLY_W'(TOP_BIN) : fixed_r;
  end

  assign bin_inc   = (&ram_rdata) ? ram_rdata : ram_rdata + CNT_ONE;
  assign ram_we    = ctl.clr_step || (ctl.ld_update && in_bins);
  assign ram_wdata = ctl.clr_step ? '0 : bin_inc;
  assign acc_sum   = acc_r + ACC_W'(prod_r);
  assign hit       = acc_sum > ACC_W'(limit_r);

  jblc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DELAY_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // address, counters and selected delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      sample_r   <= '0;
      netloss_r  <= '0;
      lateloss_r <= '0;
      eff_r      <= '0;
    end else begin
      priority if (ctl.clr_start) begin
        addr_r <= '0;
      end else if (ctl.latch) begin
        addr_r <= BIN_AW'($unsigned(in_delay_ms));
      end else if (ctl.clr_step) begin
        addr_r <= addr_r + BIN_AW'(1);
      end else if (ctl.sel_init) begin
        addr_r <= ADDR_TOP;
      end else if (ctl.sel_next) begin
        addr_r <= addr_r - BIN_AW'(1);
      end
      if (ctl.clr_start) begin
        sample_r   <= '0;
        netloss_r  <= '0;
        lateloss_r <= '0;
        eff_r      <= '0;
      end
      if (ctl.ld_update) begin
        sample_r <= (&sample_r) ? sample_r : sample_r + CNT_ONE;
      end
      if (ctl.cls_count && d_m1) begin
        netloss_r <= (&netloss_r) ? netloss_r : netloss_r + CNT_ONE;
      end
      if (ctl.cls_count && late) begin
        lateloss_r <= (&lateloss_r) ? lateloss_r : lateloss_r + CNT_ONE;
      end
      if (ctl.pick_addr) begin
        eff_r <= DLY_W'(addr_r);
      end else if (ctl.pick_fixed) begin
        eff_r <= fixed_clamp;
      end
    end
  end

  // captured item and select arithmetic
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= cmd_t'(in_command);
      dly_r <= $unsigned(in_delay_ms);
    end
    if (ctl.sel_init) begin
      limit_r <= PROD_W'(tgt_r) * PROD_W'(sample_r);
      acc_r   <= '0;
    end else if (ctl.sel_next) begin
      acc_r <= acc_sum;
    end
    if (ctl.sel_mul) begin
      prod_r <= PROD_W'(ram_rdata) * PROD_W'(LATE_SCALE);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_lost_r <= (cmd_r == CMD_CLASSIFY) && lost;
      out_last_r <= ctl.emit_last;
      out_sel_r  <= eff_r;
      out_err_r  <= ((cmd_r == CMD_LOAD) || (cmd_r == CMD_CLASSIFY)) && bad;
      out_samp_r <= sample_r;
      out_net_r  <= netloss_r;
      out_late_r <= lateloss_r;
    end
  end

  always_comb begin
    sts.cmd         = cmd_r;
    sts.clr_last    = (addr_r == ADDR_TOP);
    sts.target_zero = (tgt_r == '0);
    sts.sel_hit     = hit;
    sts.sel_bottom  = (addr_r == '0);
    sts.eff_zero    = (eff_r == '0);
    sts.two_frames  = fpp_r[1];
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_lost     = out_lost_r;
  assign out_last_of_run    = out_last_r;
  assign out_selected_delay = out_sel_r;
  assign out_range_error    = out_err_r;
  assign out_sample_count   = out_samp_r;
  assign out_network_losses = out_net_r;
  assign out_late_losses    = out_late_r;

endmodule

// File: hw/rtl/jblc_ctrl.sv
// Controller state machine: sequences clear sweep, load, select scan,
// classify and result emission. Depends on jblc_pkg.
module jblc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jblc_pkg::CMD_W-1:0]   in_command,
  input  jblc_pkg::dp_status_t         sts,
  output jblc_pkg::ctrl_cmd_t          ctl
);

  import jblc_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   clr_emit_r;
  logic   clr_emit_nxt;

  // reset starts a silent clearing sweep of the histogram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_emit_nxt = clr_emit_r;
    ctl          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch = 1'b1;
          unique case (cmd_t'(in_command))
            CMD_CLEAR: begin
              ctl.clr_start = 1'b1;
              clr_emit_nxt  = 1'b1;
              state_nxt     = ST_CLR;
            end
            CMD_LOAD:     state_nxt = ST_LD_RD;
            CMD_SELECT:   state_nxt = ST_SEL_INIT;
            CMD_CLASSIFY: state_nxt = ST_CLS;
          endcase
        end
      end
      ST_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          clr_emit_nxt = 1'b0;
          state_nxt    = clr_emit_r ? ST_EMIT_A : ST_IDLE;
        end
      end
      ST_LD_RD: state_nxt = ST_LD_WR;
      ST_LD_WR: begin
        ctl.ld_update = 1'b1;
        state_nxt     = ST_EMIT_A;
      end
      ST_SEL_INIT: begin
        ctl.sel_init = 1'b1;
        if (sts.target_zero) begin
          ctl.pick_fixed = 1'b1;
          state_nxt      = ST_EMIT_A;
        end else begin
          state_nxt = ST_SEL_RD;
        end
      end
      ST_SEL_RD: state_nxt = ST_SEL_MUL;
      ST_SEL_MUL: begin
        ctl.sel_mul = 1'b1;
        state_nxt   = ST_SEL_ACC;
      end
      ST_SEL_ACC: begin
        priority if (sts.sel_hit) begin
          ctl.pick_addr = 1'b1;
          state_nxt     = ST_EMIT_A;
        end else if (sts.sel_bottom) begin
          ctl.pick_fixed = 1'b1;
          state_nxt      = ST_EMIT_A;
        end else begin
          ctl.sel_next = 1'b1;
          state_nxt    = ST_SEL_RD;
        end
      end
      ST_CLS: begin
        // no buffer delay yet: packet is dropped without a flag
        if (sts.eff_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          ctl.cls_count = 1'b1;
          state_nxt     = ST_EMIT_A;
        end
      end
      ST_EMIT_A: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = !(sts.two_frames && (sts.cmd == CMD_CLASSIFY));
          state_nxt     = ctl.emit_last ? ST_IDLE : ST_EMIT_B;
        end
      end
      ST_EMIT_B: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/jitter_buffer_loss_classifier_top.sv
// Top level of the jitter buffer loss classifier.
// Depends on jblc_pkg, jblc_ctrl, jblc_dp (and jblc_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command with a delay sample:
//   clear, load into histogram, select buffer delay, classify packet.
//   Result channel (out_valid/out_ready) returns one status transfer per
//   clear, load and select, and one or two frame flags per classify
//   (none while the selected delay is zero).
//   Select scans the histogram from the top bin down; each bin passes
//   through the RAM read and the product register before it is accumulated.
//   A zero target takes the fixed delay without a scan.
//   One item at a time: the next is taken the cycle after the last result is
//   registered.
//   Reset: a clearing pass over all DELAY_BINS bins zeroes the histogram with
//   in_ready low; config writes are taken during it.
//   A stalled receiver holds the result register; the block then waits
//   with the next result and takes no further item.
//   cfg_we/cfg_index/cfg_wdata write a register; the user is to write only while idle, not enforced by the block.
module jitter_buffer_loss_classifier_top #(
  parameter int DELAY_BINS  = 2000,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [jblc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jblc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [jblc_pkg::CMD_W-1:0]           in_command,
  input  logic signed [jblc_pkg::DLY_IN_W-1:0] in_delay_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_frame_lost,
  output logic                                 out_last_of_run,
  output logic [jblc_pkg::DLY_W-1:0]           out_selected_delay,
  output logic                                 out_range_error,
  output logic [COUNT_WIDTH-1:0]               out_sample_count,
  output logic [COUNT_WIDTH-1:0]               out_network_losses,
  output logic [COUNT_WIDTH-1:0]               out_late_losses
);

  import jblc_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  jblc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl)
  );

  jblc_dp #(
    .DELAY_BINS  (DELAY_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_delay_ms        (in_delay_ms),
    .ctl                (ctl),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_lost     (out_frame_lost),
    .out_last_of_run    (out_last_of_run),
    .out_selected_delay (out_selected_delay),
    .out_range_error    (out_range_error),
    .out_sample_count   (out_sample_count),
    .out_network_losses (out_network_losses),
    .out_late_losses    (out_late_losses)
  );

endmodule

// File: hw/rtl/jblc_chk.sv
// Port-level checker for the jitter buffer loss classifier, with its bind.
// Depends on jblc_pkg and jitter_buffer_loss_classifier_top_assert.svh.
`include "jitter_buffer_loss_classifier_top_assert.svh"

module jblc_chk #(
  parameter int DELAY_BINS  = 2000,
  parameter int COUNT_WIDTH = 24
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [jblc_pkg::CMD_W-1:0]           in_command,
  input logic signed [jblc_pkg::DLY_IN_W-1:0] in_delay_ms,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_frame_lost,
  input logic                                 out_last_of_run,
  input logic [jblc_pkg::DLY_W-1:0]           out_selected_delay,
  input logic                                 out_range_error,
  input logic [COUNT_WIDTH-1:0]               out_sample_count,
  input logic [COUNT_WIDTH-1:0]               out_network_losses,
  input logic [COUNT_WIDTH-1:0]               out_late_losses
);

  import jblc_pkg::*;

  localparam int OUT_BUS_W = 3 + DLY_W + 3 * COUNT_WIDTH;
  localparam int IN_BUS_W  = CMD_W + DLY_IN_W;

  logic [OUT_BUS_W-1:0] out_bus;
  logic [IN_BUS_W-1:0]  in_bus;

  assign out_bus = {out_frame_lost, out_last_of_run, out_selected_delay, out_range_error,
                    out_sample_count, out_network_losses, out_late_losses};
  assign in_bus  = {in_command, in_delay_ms};

  // held result must not move while the receiver stalls
  `JBLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "result changed while stalled")

  // offered item stays put until its transfer
  `JBLC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_bus), "input changed before transfer")

  // histogram sweep follows reset, nothing pending
  `JBLC_ASSERT_SAME(a_reset_sweep, $rose(rst_n), !in_ready && !out_valid, "block ready right after reset")

  // first frame of a pair is followed at once by the closing frame
  `JBLC_ASSERT_NEXT(a_frame_pair, out_valid && out_ready && !out_last_of_run, out_valid && out_last_of_run, "second frame flag missing")

  `JBLC_ASSERT_SAME(a_delay_range, out_valid, 12'(out_selected_delay) <= 12'(DELAY_BINS - 1), "selected delay beyond top bin")

endmodule

bind jitter_buffer_loss_classifier_top jblc_chk #(
  .DELAY_BINS  (DELAY_BINS),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_jblc_chk (.*);
